@@ design/modular_square_root_defines.svh @@
// assertion macros shared by the modular square root design
`ifndef MODULAR_SQUARE_ROOT_DEFINES_SVH
`define MODULAR_SQUARE_ROOT_DEFINES_SVH

// condition in the same cycle
`define MSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// condition in the following cycle
`define MSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/msr_pkg.sv @@
// shared types and command encodings for the modular square root block
package msr_pkg;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLASS, ST_RED, ST_RED_CHK, ST_SPLIT,
        ST_PW_LOOP, ST_PW_MACC, ST_PW_MSQ, ST_PW_RET, ST_POW_T,
        ST_T_CHK, ST_Z_CHK, ST_M_INIT, ST_LOOP_TOP, ST_ORD, ST_ORD_W,
        ST_BSQ, ST_BSQ_W, ST_MR, ST_MC, ST_MT, ST_T_CHK2, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_SPLIT_INIT, OP_SPLIT_STEP, OP_PW_INIT,
        OP_PW_SHIFT, OP_MUL_START, OP_MOVE, OP_Z_INIT, OP_Z_INC,
        OP_M_FROM_S, OP_ORD_INIT, OP_K_INC, OP_B_INIT, OP_I_INC,
        OP_M_FROM_K, OP_PUBLISH
    } dp_op_t;

    typedef enum logic [3:0] {
        RID_ONE, RID_V, RID_A, RID_R, RID_T, RID_C, RID_Z, RID_B,
        RID_U, RID_ACC, RID_BASE
    } reg_id_t;

    typedef enum logic [1:0] {
        EXP_HALF, EXP_QP1H, EXP_Q
    } exp_sel_t;

    typedef enum logic [1:0] {
        RES_ROOT, RES_ZERO, RES_FAIL, RES_PARITY
    } res_sel_t;

    typedef enum logic [2:0] {
        RET_EULER, RET_R, RET_T, RET_Z, RET_C
    } ret_t;

    typedef struct packed {
        dp_op_t   op;
        reg_id_t  src;
        reg_id_t  y;
        reg_id_t  dst;
        exp_sel_t exp_sel;
        res_sel_t res_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic p_two;
        logic p_odd3;
        logic a_zero;
        logic q_even;
        logic e_zero;
        logic e_lsb;
        logic acc_one;
        logic t_one;
        logic u_one;
        logic z_ge_p;
        logic k_ge_m;
        logic i_done;
        logic m_zero;
        logic mul_done;
        logic out_free;
    } dp_stat_t;

    localparam dp_cmd_t CMD_IDLE = '{op: OP_NONE, src: RID_ONE, y: RID_ONE,
                                     dst: RID_ONE, exp_sel: EXP_HALF,
                                     res_sel: RES_FAIL};

endpackage

@@ design/msr_modmul.sv @@
// bit-serial modular multiplier, double-and-add from the top bit of y
module msr_modmul
    import msr_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W-1:0] y,
    input  logic [W-1:0] m,
    output logic         done,
    output logic [W-1:0] res
);
    localparam int IW = $clog2(W);

    logic          run_reg,  run_next;
    logic          phase_reg, phase_next;
    logic          done_reg, done_next;
    logic [IW-1:0] idx_reg,  idx_next;
    logic [W-1:0]  acc_reg,  acc_next;
    logic [W-1:0]  x_reg, y_reg, m_reg;
    logic [W-1:0]  addend, gap, sum;

    // one modular add per cycle: doubling phase or add-x phase
    always_comb
    begin
        addend = phase_reg ? x_reg : acc_reg;
        gap    = m_reg - addend;
        sum    = (acc_reg >= gap) ? (acc_reg - gap) : (acc_reg + addend);
    end

    // step sequencing
    always_comb
    begin
        run_next   = run_reg;
        phase_next = phase_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        done_next  = 1'b0;
        if (start)
        begin
            run_next   = 1'b1;
            phase_next = 1'b0;
            idx_next   = IW'(W - 1);
            acc_next   = '0;
        end
        else if (run_reg)
        begin
            acc_next = sum;
            if (!phase_reg && y_reg[idx_reg])
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                if (idx_reg == '0)
                begin
                    run_next  = 1'b0;
                    done_next = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg - 1'b1;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // operand and accumulator registers
    always_ff @(posedge clk)
    begin
        phase_reg <= phase_next;
        idx_reg   <= idx_next;
        acc_reg   <= acc_next;
        if (start)
        begin
            x_reg <= x;
            y_reg <= y;
            m_reg <= m;
        end
    end

    assign done = done_reg;
    assign res  = acc_reg;
endmodule

@@ design/msr_dp.sv @@
// datapath: working registers, counters, multiplier and result register
module msr_dp
    import msr_pkg::*;
#(
    parameter int W = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    input  logic [31:0] value,
    input  logic [31:0] modulus,
    input  logic        out_ready,
    output dp_stat_t    stat,
    output logic        out_valid,
    output logic [31:0] out_root,
    output logic        out_has
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  p_reg, v_reg, a_reg, q_reg, half_reg, r_reg, t_reg;
    logic [W-1:0]  c_reg, z_reg, b_reg, u_reg, acc_reg, base_reg, e_reg;
    logic [CW-1:0] s_reg, m_reg, k_reg, i_reg;
    reg_id_t       mdst_reg;
    logic [W-1:0]  root_reg;
    logic          has_reg, oval_reg;

    logic [W-1:0]  src_val, y_val, exp_val, wr_val, mres;
    logic [W:0]    qp1;
    logic [CW:0]   ik1;
    logic          wr_en, mdone;
    reg_id_t       wr_id;

    // operand selection
    always_comb
    begin
        case (cmd.src)
            RID_ONE:  src_val = W'(1);
            RID_V:    src_val = v_reg;
            RID_A:    src_val = a_reg;
            RID_R:    src_val = r_reg;
            RID_T:    src_val = t_reg;
            RID_C:    src_val = c_reg;
            RID_Z:    src_val = z_reg;
            RID_B:    src_val = b_reg;
            RID_U:    src_val = u_reg;
            RID_ACC:  src_val = acc_reg;
            RID_BASE: src_val = base_reg;
            default:  src_val = '0;
        endcase
        case (cmd.y)
            RID_ONE:  y_val = W'(1);
            RID_V:    y_val = v_reg;
            RID_A:    y_val = a_reg;
            RID_R:    y_val = r_reg;
            RID_T:    y_val = t_reg;
            RID_C:    y_val = c_reg;
            RID_Z:    y_val = z_reg;
            RID_B:    y_val = b_reg;
            RID_U:    y_val = u_reg;
            RID_ACC:  y_val = acc_reg;
            RID_BASE: y_val = base_reg;
            default:  y_val = '0;
        endcase
        // a product finishing this cycle is forwarded to the next start
        if (mdone && (mdst_reg == cmd.src))
            src_val = mres;
        if (mdone && (mdst_reg == cmd.y))
            y_val = mres;
    end

    // exponent selection
    always_comb
    begin
        qp1 = ({1'b0, q_reg} + 1'b1) >> 1;
        case (cmd.exp_sel)
            EXP_HALF: exp_val = half_reg;
            EXP_QP1H: exp_val = qp1[W-1:0];
            EXP_Q:    exp_val = q_reg;
            default:  exp_val = half_reg;
        endcase
    end

    // general register write: multiplier result first, else a move
    always_comb
    begin
        wr_en  = 1'b0;
        wr_id  = mdst_reg;
        wr_val = mres;
        if (mdone)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.op == OP_MOVE)
        begin
            wr_en  = 1'b1;
            wr_id  = cmd.dst;
            wr_val = src_val;
        end
    end

    msr_modmul #(.W(W)) u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.op == OP_MUL_START),
        .x     (src_val),
        .y     (y_val),
        .m     (p_reg),
        .done  (mdone),
        .res   (mres)
    );

    // working registers
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (wr_id)
                RID_A:    a_reg    <= wr_val;
                RID_R:    r_reg    <= wr_val;
                RID_T:    t_reg    <= wr_val;
                RID_C:    c_reg    <= wr_val;
                RID_B:    b_reg    <= wr_val;
                RID_U:    u_reg    <= wr_val;
                RID_ACC:  acc_reg  <= wr_val;
                RID_BASE: base_reg <= wr_val;
                default:  ;
            endcase
        end
        case (cmd.op)
            OP_LOAD:
            begin
                p_reg <= W'(modulus);
                v_reg <= W'(value);
            end
            OP_SPLIT_INIT:
            begin
                q_reg    <= p_reg - 1'b1;
                half_reg <= (p_reg - 1'b1) >> 1;
                s_reg    <= '0;
            end
            OP_SPLIT_STEP:
            begin
                q_reg <= q_reg >> 1;
                s_reg <= s_reg + 1'b1;
            end
            OP_PW_INIT:
            begin
                acc_reg  <= W'(1);
                base_reg <= src_val;
                e_reg    <= exp_val;
            end
            OP_PW_SHIFT:  e_reg <= e_reg >> 1;
            OP_MUL_START: mdst_reg <= cmd.dst;
            OP_Z_INIT:    z_reg <= W'(2);
            OP_Z_INC:     z_reg <= z_reg + 1'b1;
            OP_M_FROM_S:  m_reg <= s_reg;
            OP_ORD_INIT:
            begin
                u_reg <= t_reg;
                k_reg <= '0;
            end
            OP_K_INC:     k_reg <= k_reg + 1'b1;
            OP_B_INIT:
            begin
                b_reg <= c_reg;
                i_reg <= '0;
            end
            OP_I_INC:     i_reg <= i_reg + 1'b1;
            OP_M_FROM_K:  m_reg <= k_reg;
            OP_PUBLISH:
            begin
                case (cmd.res_sel)
                    RES_ROOT:
                    begin
                        root_reg <= r_reg;
                        has_reg  <= 1'b1;
                    end
                    RES_ZERO:
                    begin
                        root_reg <= '0;
                        has_reg  <= 1'b1;
                    end
                    RES_PARITY:
                    begin
                        root_reg <= W'(v_reg[0]);
                        has_reg  <= 1'b1;
                    end
                    default:
                    begin
                        root_reg <= '0;
                        has_reg  <= 1'b0;
                    end
                endcase
            end
            default: ;
        endcase
    end

    // output transaction valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            oval_reg <= 1'b0;
        else if (cmd.op == OP_PUBLISH)
            oval_reg <= 1'b1;
        else if (out_ready)
            oval_reg <= 1'b0;
    end

    // status to the controller
    always_comb
    begin
        ik1           = {1'b0, i_reg} + {1'b0, k_reg} + 1'b1;
        stat.p_two    = (p_reg == W'(2));
        stat.p_odd3   = p_reg[0] && (p_reg != W'(1));
        stat.a_zero   = (a_reg == '0);
        stat.q_even   = !q_reg[0];
        stat.e_zero   = (e_reg == '0);
        stat.e_lsb    = e_reg[0];
        stat.acc_one  = (acc_reg == W'(1));
        stat.t_one    = (t_reg == W'(1));
        stat.u_one    = (u_reg == W'(1));
        stat.z_ge_p   = (z_reg >= p_reg);
        stat.k_ge_m   = (k_reg >= m_reg);
        stat.i_done   = (ik1 >= {1'b0, m_reg});
        stat.m_zero   = (m_reg == '0);
        stat.mul_done = mdone;
        stat.out_free = !oval_reg || out_ready;
    end

    assign out_valid = oval_reg;
    assign out_root  = 32'(root_reg);
    assign out_has   = has_reg;
endmodule

@@ design/msr_ctrl.sv @@
// controller state machine sequencing the square root steps
module msr_ctrl
    import msr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  dp_stat_t stat,
    output logic     in_ready,
    output dp_cmd_t  cmd
);
    state_t   state_reg, state_next;
    ret_t     ret_reg, ret_next;
    res_sel_t res_reg, res_next;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_EULER;
            res_reg   <= RES_FAIL;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            res_reg   <= res_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        res_next   = res_reg;
        cmd        = CMD_IDLE;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_CLASS;
                end
            end
            // modulus two, unusable modulus, or start reduction of the value
            ST_CLASS:
            begin
                if (stat.p_two)
                begin
                    res_next   = RES_PARITY;
                    state_next = ST_DONE;
                end
                else if (!stat.p_odd3)
                begin
                    res_next   = RES_FAIL;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = OP_MUL_START;
                    cmd.src    = RID_ONE;
                    cmd.y      = RID_V;
                    cmd.dst    = RID_A;
                    state_next = ST_RED;
                end
            end
            ST_RED:
            begin
                if (stat.mul_done)
                    state_next = ST_RED_CHK;
            end
            ST_RED_CHK:
            begin
                if (stat.a_zero)
                begin
                    res_next   = RES_ZERO;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = OP_SPLIT_INIT;
                    state_next = ST_SPLIT;
                end
            end
            // strip factors of two from p minus one, then euler test
            ST_SPLIT:
            begin
                if (stat.q_even)
                begin
                    cmd.op = OP_SPLIT_STEP;
                end
                else
                begin
                    cmd.op      = OP_PW_INIT;
                    cmd.src     = RID_A;
                    cmd.exp_sel = EXP_HALF;
                    ret_next    = RET_EULER;
                    state_next  = ST_PW_LOOP;
                end
            end
            // modular power, exponent bits from the bottom
            ST_PW_LOOP:
            begin
                if (stat.e_zero)
                begin
                    state_next = ST_PW_RET;
                end
                else if (stat.e_lsb)
                begin
                    cmd.op     = OP_MUL_START;
                    cmd.src    = RID_ACC;
                    cmd.y      = RID_BASE;
                    cmd.dst    = RID_ACC;
                    state_next = ST_PW_MACC;
                end
                else
                begin
                    cmd.op     = OP_MUL_START;
                    cmd.src    = RID_BASE;
                    cmd.y      = RID_BASE;
                    cmd.dst    = RID_BASE;
                    state_next = ST_PW_MSQ;
                end
            end
            ST_PW_MACC:
            begin
                if (stat.mul_done)
                begin
                    cmd.op     = OP_MUL_START;
                    cmd.src    = RID_BASE;
                    cmd.y      = RID_BASE;
                    cmd.dst    = RID_BASE;
                    state_next = ST_PW_MSQ;
                end
            end
            ST_PW_MSQ:
            begin
                if (stat.mul_done)
                begin
                    cmd.op     = OP_PW_SHIFT;
                    state_next = ST_PW_LOOP;
                end
            end
            // power finished: continue with the caller
            ST_PW_RET:
            begin
                case (ret_reg)
                    RET_EULER:
                    begin
                        if (!stat.acc_one)
                        begin
                            res_next   = RES_FAIL;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            cmd.op      = OP_PW_INIT;
                            cmd.src     = RID_A;
                            cmd.exp_sel = EXP_QP1H;
                            ret_next    = RET_R;
                            state_next  = ST_PW_LOOP;
                        end
                    end
                    RET_R:
                    begin
                        cmd.op     = OP_MOVE;
                        cmd.src    = RID_ACC;
                        cmd.dst    = RID_R;
                        state_next = ST_POW_T;
                    end
                    RET_T:
                    begin
                        cmd.op     = OP_MOVE;
                        cmd.src    = RID_ACC;
                        cmd.dst    = RID_T;
                        state_next = ST_T_CHK;
                    end
                    RET_Z:
                    begin
                        if (stat.acc_one)
                        begin
                            cmd.op     = OP_Z_INC;
                            state_next = ST_Z_CHK;
                        end
                        else
                        begin
                            cmd.op      = OP_PW_INIT;
                            cmd.src     = RID_Z;
                            cmd.exp_sel = EXP_Q;
                            ret_next    = RET_C;
                            state_next  = ST_PW_LOOP;
                        end
                    end
                    default:
                    begin
                        cmd.op     = OP_MOVE;
                        cmd.src    = RID_ACC;
                        cmd.dst    = RID_C;
                        state_next = ST_M_INIT;
                    end
                endcase
            end
            ST_POW_T:
            begin
                cmd.op      = OP_PW_INIT;
                cmd.src     = RID_A;
                cmd.exp_sel = EXP_Q;
                ret_next    = RET_T;
                state_next  = ST_PW_LOOP;
            end
            ST_T_CHK:
            begin
                if (stat.t_one)
                begin
                    res_next   = RES_ROOT;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = OP_Z_INIT;
                    state_next = ST_Z_CHK;
                end
            end
            // non-residue scan
            ST_Z_CHK:
            begin
                if (stat.z_ge_p)
                begin
                    res_next   = RES_FAIL;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op      = OP_PW_INIT;
                    cmd.src     = RID_Z;
                    cmd.exp_sel = EXP_HALF;
                    ret_next    = RET_Z;
                    state_next  = ST_PW_LOOP;
                end
            end
            ST_M_INIT:
            begin
                cmd.op     = OP_M_FROM_S;
                state_next = ST_LOOP_TOP;
            end
            // main loop: find order of t
            ST_LOOP_TOP:
            begin
                if (stat.m_zero)
                begin
                    res_next   = RES_FAIL;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.op     = OP_ORD_INIT;
                    state_next = ST_ORD;
                end
            end
            ST_ORD:
            begin
                if (stat.k_ge_m)
                begin
                    res_next   = RES_FAIL;
                    state_next = ST_DONE;
                end
                else if (stat.u_one)
                begin
                    cmd.op     = OP_B_INIT;
                    state_next = ST_BSQ;
                end
                else
                begin
                    cmd.op     = OP_MUL_START;
                    cmd.src    = RID_U;
                    cmd.y      = RID_U;
                    cmd.dst    = RID_U;
                    state_next = ST_ORD_W;
                end
            end
            ST_ORD_W:
            begin
                if (stat.mul_done)
                begin
                    cmd.op     = OP_K_INC;
                    state_next = ST_ORD;
                end
            end
            // square c down to the correction factor b
            ST_BSQ:
            begin
                if (stat.i_done)
                begin
                    cmd.op     = OP_MUL_START;
                    cmd.src    = RID_R;
                    cmd.y      = RID_B;
                    cmd.dst    = RID_R;
                    state_next = ST_MR;
                end
                else
                begin
                    cmd.op     = OP_MUL_START;
                    cmd.src    = RID_B;
                    cmd.y      = RID_B;
                    cmd.dst    = RID_B;
                    state_next = ST_BSQ_W;
                end
            end
            ST_BSQ_W:
            begin
                if (stat.mul_done)
                begin
                    cmd.op     = OP_I_INC;
                    state_next = ST_BSQ;
                end
            end
            // update r, c and t
            ST_MR:
            begin
                if (stat.mul_done)
                begin
                    cmd.op     = OP_MUL_START;
                    cmd.src    = RID_B;
                    cmd.y      = RID_B;
                    cmd.dst    = RID_C;
                    state_next = ST_MC;
                end
            end
            ST_MC:
            begin
                if (stat.mul_done)
                begin
                    cmd.op     = OP_MUL_START;
                    cmd.src    = RID_T;
                    cmd.y      = RID_C;
                    cmd.dst    = RID_T;
                    state_next = ST_MT;
                end
            end
            ST_MT:
            begin
                if (stat.mul_done)
                begin
                    cmd.op     = OP_M_FROM_K;
                    state_next = ST_T_CHK2;
                end
            end
            ST_T_CHK2:
            begin
                if (stat.t_one)
                begin
                    res_next   = RES_ROOT;
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_LOOP_TOP;
                end
            end
            // hand the result to the output register once it is free
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op      = OP_PUBLISH;
                    cmd.res_sel = res_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

@@ design/modular_square_root.sv @@
// Modular square root (Tonelli-Shanks) for a programmable odd prime modulus.
// One transaction at a time: an input is taken only while the sequencer is
// idle, and the result sits in an output register so the next input can be
// taken while it waits. Latency is data dependent and set by the shared
// bit-serial modular multiplier, whose time per product grows with the
// number of set bits of its second operand. A residue test and each later
// exponentiation costs up to about 2*PRIME_BITS products, the non-residue
// scan repeats one exponentiation per candidate, and the correction loop
// adds up to about PRIME_BITS^2 squarings. Zero input gives root 0 with
// has_root set; a non-residue gives root 0 with has_root clear; the other
// root is the modulus minus root.
module modular_square_root
    import msr_pkg::*;
#(
    parameter int PRIME_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,   // prime_modulus
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,     // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,     // [31:0] root
    output logic        m_tuser      // [0] has_root
);
`include "modular_square_root_defines.svh"

    logic [31:0] modulus_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    // modulus configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            modulus_reg <= 32'd3;
        else if (cfg_we)
            modulus_reg <= cfg_wdata;
    end

    msr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .stat     (stat),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    msr_dp #(.W(PRIME_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .value     (s_tdata),
        .modulus   (modulus_reg),
        .out_ready (m_tready),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_root  (m_tdata),
        .out_has   (m_tuser)
    );

    // checks
    `MSR_ASSERT_NOW(a_fail_zero_root, m_tvalid && !m_tuser, m_tdata == 32'd0, "no-root result with nonzero root")
    `MSR_ASSERT_NEXT(a_busy_after_take, s_tvalid && s_tready, !s_tready, "input taken while busy")
    `MSR_ASSERT_NEXT(a_publish_sets_valid, cmd.op == OP_PUBLISH, m_tvalid, "result lost at publish")
endmodule
